// ===== rtl/ast_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the assembly source tokenizer
// Token kinds, error codes, scan modes and the opcode table.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int DefPositionBits = 20;
  localparam int DefLineBits     = 16;
  localparam int DefLengthBits   = 16;

  localparam int NumOps = 27;
  localparam logic [4:0] NOT_OP = 5'd27;

  typedef enum logic [2:0] {
    KIND_OPCODE = 3'd0,
    KIND_REG    = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_IMM    = 3'd3,
    KIND_COMMA  = 3'd4,
    KIND_COLON  = 3'd5,
    KIND_END    = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MINUS    = 3'd1,
    ERR_CHAR     = 3'd2,
    ERR_HEX      = 3'd3,
    ERR_RANGE    = 3'd4
  } err_t;

  typedef enum logic [8:0] {
    M_IDLE     = 9'b000000001,
    M_COMMENT  = 9'b000000010,
    M_WORD     = 9'b000000100,
    M_MINUS    = 9'b000001000,
    M_ZERO     = 9'b000010000,
    M_DEC      = 9'b000100000,
    M_HEXSTART = 9'b001000000,
    M_HEX      = 9'b010000000,
    M_ERROR    = 9'b100000000
  } mode_t;

  // Control of one token slot, passed from the scanner to the output stage
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    err_t        err;
    logic [4:0]  opi;
    logic [2:0]  regn;
    logic [31:0] imm;
  } tok_t;

  // Opcode name packed big-endian in 32 bits, length in the low 3 bits
  function automatic logic [34:0] op_entry(input logic [4:0] i);
    logic [34:0] e;
    begin
      unique case (i)
        5'd0:  e = {32'h00616461, 3'd3};
        5'd1:  e = {32'h0061647a, 3'd3};
        5'd2:  e = {32'h00616463, 3'd3};
        5'd3:  e = {32'h00617763, 3'd3};
        5'd4:  e = {32'h00616361, 3'd3};
        5'd5:  e = {32'h0061637a, 3'd3};
        5'd6:  e = {32'h00616363, 3'd3};
        5'd7:  e = {32'h00616377, 3'd3};
        5'd8:  e = {32'h006e6475, 3'd3};
        5'd9:  e = {32'h006e647a, 3'd3};
        5'd10: e = {32'h006e6463, 3'd3};
        5'd11: e = {32'h006e6375, 3'd3};
        5'd12: e = {32'h006e637a, 3'd3};
        5'd13: e = {32'h006e6363, 3'd3};
        5'd14: e = {32'h00616469, 3'd3};
        5'd15: e = {32'h006c6c69, 3'd3};
        5'd16: e = {32'h00006c77, 3'd2};
        5'd17: e = {32'h00007377, 3'd2};
        5'd18: e = {32'h00006c6d, 3'd2};
        5'd19: e = {32'h0000736d, 3'd2};
        5'd20: e = {32'h00626571, 3'd3};
        5'd21: e = {32'h00626c74, 3'd3};
        5'd22: e = {32'h00626c65, 3'd3};
        5'd23: e = {32'h006a616c, 3'd3};
        5'd24: e = {32'h006a6c72, 3'd3};
        5'd25: e = {32'h006a7269, 3'd3};
        5'd26: e = {32'h68616c74, 3'd4};
        default: e = '0;
      endcase
      return e;
    end
  endfunction

endpackage

// ===== rtl/ast_word_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_word_match: classify a finished word
// Compares the packed prefix against the opcode table, then r0-r7.
// ----------------------------------------------------------------------------
module ast_word_match #(
  parameter int LENGTH_BITS = ast_pkg::DefLengthBits
) (
  input  logic [31:0]            prefix,
  input  logic [LENGTH_BITS-1:0] len,
  output ast_pkg::tok_t          tok
);
  import ast_pkg::*;

  logic        hit;
  logic [4:0]  hit_idx;
  logic [34:0] ent;
  logic        short_word;

  assign short_word = (len <= LENGTH_BITS'(4));

  // Search the table; first match wins
  always_comb begin
    hit = 1'b0;
    hit_idx = NOT_OP;
    ent = '0;
    for (int i = NumOps - 1; i >= 0; i--) begin
      ent = op_entry(5'(i));
      if (short_word && (len == LENGTH_BITS'(ent[2:0])) && (prefix == ent[34:3])) begin
        hit = 1'b1;
        hit_idx = 5'(i);
      end
    end
  end

  always_comb begin
    tok = '0;
    tok.valid = 1'b1;
    tok.opi = NOT_OP;
    tok.err = ERR_NONE;
    if (hit) begin
      tok.kind = KIND_OPCODE;
      tok.opi = hit_idx;
    end else if (len == LENGTH_BITS'(2) && prefix[15:8] == 8'h72 &&
                 prefix[7:0] >= 8'h30 && prefix[7:0] <= 8'h37) begin
      tok.kind = KIND_REG;
      tok.regn = prefix[2:0];
    end else begin
      tok.kind = KIND_IDENT;
    end
  end

endmodule

// ===== rtl/ast_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_scanner: character scanner
// Holds the scan state and computes up to two token slots for one beat.
// ----------------------------------------------------------------------------
module ast_scanner #(
  parameter int POSITION_BITS = ast_pkg::DefPositionBits,
  parameter int LINE_BITS     = ast_pkg::DefLineBits,
  parameter int LENGTH_BITS   = ast_pkg::DefLengthBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               ch,
  input  logic                     is_end,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_line,
  output ast_pkg::tok_t            tok0,
  output ast_pkg::tok_t            tok1,
  output logic [LINE_BITS-1:0]     line0,
  output logic [LINE_BITS-1:0]     line1,
  output logic [POSITION_BITS-1:0] start0,
  output logic [POSITION_BITS-1:0] start1,
  output logic [LENGTH_BITS-1:0]   len0,
  output logic [LENGTH_BITS-1:0]   len1
);
  import ast_pkg::*;

  localparam logic [LINE_BITS-1:0]   LineMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenMax  = '1;

  mode_t                    mode, mode_next;
  logic [LINE_BITS-1:0]     line_count, line_count_next, line_init;
  logic [POSITION_BITS-1:0] char_position, char_position_next;
  logic [POSITION_BITS-1:0] pending_start, pending_start_next;
  logic [LENGTH_BITS-1:0]   pending_length, pending_length_next;
  logic [31:0]              magnitude, magnitude_next;
  logic                     negative, negative_next;
  logic                     overflow, overflow_next;
  logic [31:0]              prefix, prefix_next;
  logic [15:0]              first_line;

  tok_t word_tok;
  logic is_dig, is_alp, is_wc, is_hex;
  logic [7:0] low_c, hex_d;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [35:0] dec_acc, hex_acc;
  logic [31:0] limit;
  logic num_bad;
  logic do_idle;
  logic [LINE_BITS-1:0] line_after;

  ast_word_match #(.LENGTH_BITS(LENGTH_BITS)) u_match (
    .prefix(prefix), .len(pending_length), .tok(word_tok)
  );

  // Saturate the configured first line into the line counter width
  always_comb begin
    if (LINE_BITS >= 16) line_init = LINE_BITS'(first_line);
    else if ((first_line >> LINE_BITS) != 16'd0) line_init = LineMax;
    else line_init = LINE_BITS'(first_line);
  end

  // Character classes
  assign is_dig = (ch >= 8'h30 && ch <= 8'h39);
  assign is_alp = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
  assign is_wc  = is_dig || is_alp || ch == 8'h5f;
  assign low_c  = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;
  always_comb begin
    is_hex = 1'b1;
    hex_d = 8'd0;
    if (is_dig) hex_d = ch - 8'h30;
    else if (low_c >= 8'h61 && low_c <= 8'h66) hex_d = low_c - 8'h57;
    else is_hex = 1'b0;
  end
  assign len_inc = (pending_length < LenMax) ? pending_length + 1'b1 : pending_length;
  assign dec_acc = {4'd0, magnitude} * 36'd10 + {28'd0, ch - 8'h30};
  assign hex_acc = {magnitude, 4'd0} + {28'd0, hex_d};
  assign limit   = negative ? 32'h80000000 : 32'h7fffffff;
  assign num_bad = overflow || (magnitude > limit);

  function automatic tok_t mk(input kind_t k, input err_t e);
    tok_t t;
    begin
      t = '0;
      t.valid = 1'b1;
      t.kind = k;
      t.err = e;
      t.opi = NOT_OP;
      return t;
    end
  endfunction

  // Next state and token slots for one beat
  always_comb begin
    mode_next = mode;
    line_count_next = line_count;
    char_position_next = char_position;
    pending_start_next = pending_start;
    pending_length_next = pending_length;
    magnitude_next = magnitude;
    negative_next = negative;
    overflow_next = overflow;
    prefix_next = prefix;
    tok0 = '0;
    tok1 = '0;
    start0 = pending_start;
    start1 = char_position;
    len0 = pending_length;
    len1 = LENGTH_BITS'(1);
    do_idle = 1'b0;
    line_after = line_count;

    if (is_end) begin
      // Flush the pending token, then the end marker
      unique case (mode)
        M_WORD: tok0 = word_tok;
        M_ZERO, M_DEC, M_HEX: begin
          tok0 = num_bad ? mk(KIND_ERROR, ERR_RANGE) : mk(KIND_IMM, ERR_NONE);
          if (!num_bad) tok0.imm = negative ? 32'd0 - magnitude : magnitude;
        end
        M_MINUS: tok0 = mk(KIND_ERROR, ERR_MINUS);
        M_HEXSTART: tok0 = mk(KIND_ERROR, ERR_HEX);
        default: tok0 = '0;
      endcase
      tok1 = mk(KIND_END, ERR_NONE);
      len1 = '0;
      mode_next = M_IDLE;
      line_count_next = line_init;
      char_position_next = '0;
      pending_start_next = '0;
      pending_length_next = '0;
      magnitude_next = '0;
      negative_next = 1'b0;
      overflow_next = 1'b0;
      prefix_next = '0;
    end else begin
      char_position_next = char_position + 1'b1;
      unique case (mode)
        M_ERROR: ;
        M_COMMENT: if (ch == 8'h0a) do_idle = 1'b1;
        M_WORD: begin
          if (is_wc) begin
            if (pending_length < LENGTH_BITS'(4)) prefix_next = {prefix[23:0], low_c};
            pending_length_next = len_inc;
          end else begin
            tok0 = word_tok;
            do_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_dig) begin
            magnitude_next = {24'd0, ch - 8'h30};
            pending_length_next = len_inc;
            mode_next = (ch == 8'h30) ? M_ZERO : M_DEC;
          end else begin
            tok0 = mk(KIND_ERROR, ERR_MINUS);
            mode_next = M_ERROR;
          end
        end
        M_ZERO, M_DEC: begin
          if (mode == M_ZERO && (ch == 8'h78 || ch == 8'h58)) begin
            pending_length_next = len_inc;
            mode_next = M_HEXSTART;
          end else if (is_dig) begin
            magnitude_next = dec_acc[31:0];
            if (dec_acc[35:32] != 4'd0) overflow_next = 1'b1;
            pending_length_next = len_inc;
            mode_next = M_DEC;
          end else if (num_bad) begin
            tok0 = mk(KIND_ERROR, ERR_RANGE);
            mode_next = M_ERROR;
          end else begin
            tok0 = mk(KIND_IMM, ERR_NONE);
            tok0.imm = negative ? 32'd0 - magnitude : magnitude;
            do_idle = 1'b1;
          end
        end
        M_HEXSTART, M_HEX: begin
          if (is_hex) begin
            magnitude_next = hex_acc[31:0];
            if (hex_acc[35:32] != 4'd0) overflow_next = 1'b1;
            pending_length_next = len_inc;
            mode_next = M_HEX;
          end else if (mode == M_HEXSTART) begin
            tok0 = mk(KIND_ERROR, ERR_HEX);
            mode_next = M_ERROR;
          end else if (num_bad) begin
            tok0 = mk(KIND_ERROR, ERR_RANGE);
            mode_next = M_ERROR;
          end else begin
            tok0 = mk(KIND_IMM, ERR_NONE);
            tok0.imm = negative ? 32'd0 - magnitude : magnitude;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Handle the character from the idle state
      if (do_idle) begin
        mode_next = M_IDLE;
        if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0d) begin
        end else if (ch == 8'h0a) begin
          if (line_count < LineMax) line_count_next = line_count + 1'b1;
          line_after = line_count_next;
        end else if (ch == 8'h2c) begin
          tok1 = mk(KIND_COMMA, ERR_NONE);
        end else if (ch == 8'h3a) begin
          tok1 = mk(KIND_COLON, ERR_NONE);
        end else if (ch == 8'h3b) begin
          mode_next = M_COMMENT;
        end else if (ch == 8'h2d || is_dig || is_alp || ch == 8'h5f) begin
          pending_start_next = char_position;
          pending_length_next = LENGTH_BITS'(1);
          overflow_next = 1'b0;
          negative_next = (ch == 8'h2d);
          magnitude_next = is_dig ? {24'd0, ch - 8'h30} : 32'd0;
          prefix_next = (is_alp || ch == 8'h5f) ? {24'd0, low_c} : 32'd0;
          if (ch == 8'h2d) mode_next = M_MINUS;
          else if (ch == 8'h30) mode_next = M_ZERO;
          else if (is_dig) mode_next = M_DEC;
          else mode_next = M_WORD;
        end else begin
          tok1 = mk(KIND_ERROR, ERR_CHAR);
          mode_next = M_ERROR;
        end
      end
    end
    line0 = line_count;
    line1 = is_end ? line_count : line_after;
  end

  // Hold the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      first_line <= 16'd1;
      line_count <= LINE_BITS'(1);
      char_position <= '0;
      pending_start <= '0;
      pending_length <= '0;
      magnitude <= '0;
      negative <= 1'b0;
      overflow <= 1'b0;
      prefix <= '0;
    end else if (cfg_we) begin
      first_line <= cfg_line;
      if (LINE_BITS < 16 && (cfg_line >> LINE_BITS) != 16'd0) line_count <= LineMax;
      else line_count <= LINE_BITS'(cfg_line);
    end else if (step) begin
      mode <= mode_next;
      line_count <= line_count_next;
      char_position <= char_position_next;
      pending_start <= pending_start_next;
      pending_length <= pending_length_next;
      magnitude <= magnitude_next;
      negative <= negative_next;
      overflow <= overflow_next;
      prefix <= prefix_next;
    end
  end

endmodule

// ===== rtl/ast_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_out_stage: result register pair
// Holds up to two tokens of one beat and drains them one per output beat.
// ----------------------------------------------------------------------------
module ast_out_stage #(
  parameter int POSITION_BITS = ast_pkg::DefPositionBits,
  parameter int LINE_BITS     = ast_pkg::DefLineBits,
  parameter int LENGTH_BITS   = ast_pkg::DefLengthBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  ast_pkg::tok_t            tok0,
  input  ast_pkg::tok_t            tok1,
  input  logic [LINE_BITS-1:0]     line0,
  input  logic [LINE_BITS-1:0]     line1,
  input  logic [POSITION_BITS-1:0] start0,
  input  logic [POSITION_BITS-1:0] start1,
  input  logic [LENGTH_BITS-1:0]   len0,
  input  logic [LENGTH_BITS-1:0]   len1,
  output logic                     can_load,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ast_pkg::tok_t            head,
  output logic [LINE_BITS-1:0]     head_line,
  output logic [POSITION_BITS-1:0] head_start,
  output logic [LENGTH_BITS-1:0]   head_len,
  output logic                     head_last
);
  import ast_pkg::*;

  tok_t a_tok, b_tok;
  logic [LINE_BITS-1:0] a_line, b_line;
  logic [POSITION_BITS-1:0] a_start, b_start;
  logic [LENGTH_BITS-1:0] a_len, b_len;
  logic drain;

  assign out_valid = a_tok.valid;
  assign drain = out_ready && a_tok.valid;
  // Accept when slot A is empty or frees this cycle and B is empty
  assign can_load = !b_tok.valid && (!a_tok.valid || out_ready);
  assign head = a_tok;
  assign head_line = a_line;
  assign head_start = a_start;
  assign head_len = a_len;
  assign head_last = !b_tok.valid;

  // Advance the pair: B moves to A on drain, new beat fills one or both slots
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok.valid <= 1'b0;
      b_tok.valid <= 1'b0;
    end else if (load) begin
      if (tok0.valid) begin
        a_tok <= tok0; a_line <= line0; a_start <= start0; a_len <= len0;
        b_tok <= tok1; b_line <= line1; b_start <= start1; b_len <= len1;
      end else begin
        a_tok <= tok1; a_line <= line1; a_start <= start1; a_len <= len1;
        b_tok.valid <= 1'b0;
      end
    end else if (drain) begin
      a_tok <= b_tok; a_line <= b_line; a_start <= b_start; a_len <= b_len;
      b_tok.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/assembly_source_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_source_tokenizer: streaming assembly lexer
// One character beat in, zero to two token beats out.
// ----------------------------------------------------------------------------
// A character beat is taken in any cycle in which the result pair holds no
// second token and its head token is empty or leaving, so characters stream
// at one per cycle while the token side keeps up. A beat that gives two
// tokens (a word or number flushed by a comma, colon or bad character, or a
// pending token flushed by the end marker) blocks input while the second
// token drains. The first token appears in the cycle after its input beat.
// Write first_line only while the block is idle.
module assembly_source_tokenizer #(
  parameter int POSITION_BITS = ast_pkg::DefPositionBits,
  parameter int LINE_BITS     = ast_pkg::DefLineBits,
  parameter int LENGTH_BITS   = ast_pkg::DefLengthBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                ch,
  input  logic                      is_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                token_kind,
  output logic [2:0]                error_code,
  output logic [4:0]                opcode_index,
  output logic [2:0]                register_number,
  output logic signed [31:0]        immediate_value,
  output logic [LINE_BITS-1:0]      line_number,
  output logic [POSITION_BITS-1:0]  token_start,
  output logic [LENGTH_BITS-1:0]    token_length,
  output logic                      last
);
  import ast_pkg::*;

  tok_t tok0, tok1, head;
  logic [LINE_BITS-1:0] line0, line1;
  logic [POSITION_BITS-1:0] start0, start1;
  logic [LENGTH_BITS-1:0] len0, len1;
  logic step, cfg_we;
  logic [15:0] first_line;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 1'b0);
  assign step = in_valid && in_ready;

  // Shadow of the register for reads
  always_ff @(posedge clk) begin
    if (rst) begin
      first_line <= 16'd1;
    end else if (cfg_we) begin
      first_line <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == 1'b0) ? {16'd0, first_line} : 32'd0;

  ast_scanner #(
    .POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk(clk), .rst(rst), .step(step), .ch(ch), .is_end(is_end),
    .cfg_we(cfg_we), .cfg_line(pwdata[15:0]),
    .tok0(tok0), .tok1(tok1), .line0(line0), .line1(line1),
    .start0(start0), .start1(start1), .len0(len0), .len1(len1)
  );

  ast_out_stage #(
    .POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)
  ) u_out (
    .clk(clk), .rst(rst), .load(step && (tok0.valid || tok1.valid)),
    .tok0(tok0), .tok1(tok1), .line0(line0), .line1(line1),
    .start0(start0), .start1(start1), .len0(len0), .len1(len1),
    .can_load(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .head(head), .head_line(line_number), .head_start(token_start),
    .head_len(token_length), .head_last(last)
  );

  assign token_kind = head.kind;
  assign error_code = head.err;
  assign opcode_index = head.opi;
  assign register_number = head.regn;
  assign immediate_value = head.imm;

endmodule

// ===== rtl/ast_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_checker: port-level checks of the tokenizer
// Watches the result channel for consistent token fields.
// ----------------------------------------------------------------------------
module ast_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] token_kind,
  input logic [2:0] error_code,
  input logic [4:0] opcode_index,
  input logic       last
);
  import ast_pkg::*;

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind))
    else $error("stalled token changed");

  // Error code only on error tokens
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("error code on non-error token");

  // Opcode index only on opcode tokens
  a_opi: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_OPCODE |-> opcode_index == NOT_OP)
    else $error("opcode index on non-opcode token");

  // End token always closes its beat
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> last)
    else $error("end token not last");

endmodule

bind assembly_source_tokenizer ast_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .token_kind(token_kind), .error_code(error_code),
  .opcode_index(opcode_index), .last(last)
);
